// ===== rtl/core/bang_bang_servo_accel_command_assert.svh =====
// Assertion macros for the bang-bang servo acceleration command block
`ifndef BANG_BANG_SERVO_ACCEL_COMMAND_ASSERT_SVH
`define BANG_BANG_SERVO_ACCEL_COMMAND_ASSERT_SVH
`ifndef ASSERT_OFF
`define BBSAC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBSAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) else $error(msg);
`else
`define BBSAC_ASSERT(label, clk, rst_n, prop, msg)
`define BBSAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/bbsac_pkg.sv =====
// Shared types and constants of the servo acceleration command block
package bbsac_pkg;

	localparam int unsigned CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE_THRESHOLD = 3'd0,
		REG_RATE_LIMIT     = 3'd1,
		REG_ACCEL_LIMIT    = 3'd2,
		REG_RATE_GAIN      = 3'd3,
		REG_ACCEL_GAIN     = 3'd4,
		REG_LOWER_STOP     = 3'd5,
		REG_UPPER_STOP     = 3'd6,
		REG_STOPS_ENABLED  = 3'd7
	} cfg_reg_t;

endpackage

// ===== rtl/core/bang_bang_servo_accel_command.sv =====
// Bang-bang servo acceleration command with a linear zone, seven-stage pipeline
// A sample (position_error, position, rate) is taken at every clock edge where start is
// high; busy is always low, so one word can enter each cycle. The result is on
// position_derivative, accel_command and bang_mode, marked by done for one cycle once the
// sample has passed the seven register stages; the receiver cannot stall and must take it
// then. The stages are: input capture, error and rate products, stopping test and rate
// clamp, rate error, its magnitude, acceleration gain product, then clamp and sign.
// Configuration writes take effect at once and should only be made with the pipe empty.
`include "bang_bang_servo_accel_command_assert.svh"

module bang_bang_servo_accel_command import bbsac_pkg::*; #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] position_error,
	input  logic signed [VALUE_WIDTH-1:0] position,
	input  logic signed [VALUE_WIDTH-1:0] rate,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] position_derivative,
	output logic signed [VALUE_WIDTH-1:0] accel_command,
	output logic                          bang_mode,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [VALUE_WIDTH-1:0]        cfg_data
);

	localparam int W       = VALUE_WIDTH;
	localparam int PW      = 2 * VALUE_WIDTH;
	localparam int LATENCY = 7;

	localparam logic [W-2:0] ONE_Q = (W-1)'(64'd1 << FRACTION_BITS);
	localparam logic [W-2:0] TEN_Q = (W-1)'(64'd10 << FRACTION_BITS);
	localparam logic [W-2:0] MAG_MAX = '1;
	localparam logic signed [W-1:0] POS_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};

	// configuration registers
	logic [W-2:0]        mode_threshold_q;
	logic [W-2:0]        rate_limit_q;
	logic [W-2:0]        accel_limit_q;
	logic [W-2:0]        rate_gain_q;
	logic [W-2:0]        accel_gain_q;
	logic signed [W-1:0] lower_stop_q;
	logic signed [W-1:0] upper_stop_q;
	logic                stops_enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_threshold_q <= TEN_Q;
			rate_limit_q     <= MAG_MAX;
			accel_limit_q    <= ONE_Q;
			rate_gain_q      <= ONE_Q;
			accel_gain_q     <= ONE_Q;
			lower_stop_q     <= POS_MIN;
			upper_stop_q     <= POS_MAX;
			stops_enabled_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE_THRESHOLD: mode_threshold_q <= cfg_data[W-2:0];
				REG_RATE_LIMIT:     rate_limit_q     <= cfg_data[W-2:0];
				REG_ACCEL_LIMIT:    accel_limit_q    <= cfg_data[W-2:0];
				REG_RATE_GAIN:      rate_gain_q      <= cfg_data[W-2:0];
				REG_ACCEL_GAIN:     accel_gain_q     <= cfg_data[W-2:0];
				REG_LOWER_STOP:     lower_stop_q     <= $signed(cfg_data);
				REG_UPPER_STOP:     upper_stop_q     <= $signed(cfg_data);
				REG_STOPS_ENABLED:  stops_enabled_q  <= cfg_data[0];
			endcase
		end
	end

	assign busy = 1'b0;

	// valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// stage 1: magnitudes, signs, mode select
	logic [W-1:0] pe_u, rate_u, aerr_c, arate_c;
	logic         at_stop_c, bang_c;

	always_comb begin
		pe_u      = position_error;
		rate_u    = rate;
		aerr_c    = position_error[W-1] ? (~pe_u + 1'b1) : pe_u;
		arate_c   = rate[W-1] ? (~rate_u + 1'b1) : rate_u;
		at_stop_c = stops_enabled_q && (position == lower_stop_q || position == upper_stop_q);
		bang_c    = aerr_c > {1'b0, mode_threshold_q};
	end

	logic [W-1:0]        aerr_s1, arate_s1;
	logic                err_neg_s1, rate_neg_s1, at_stop_s1, bang_s1;
	logic signed [W-1:0] rate_s1;

	// stage 2: products
	logic [PW-1:0]       rsq_s2;
	logic [PW-2:0]       reach_s2, crprod_s2;
	logic                err_neg_s2, rate_neg_s2, at_stop_s2, bang_s2;
	logic signed [W-1:0] rate_s2;

	// stage 3: stopping test, commanded-rate clamp
	logic [PW-2:0]       crsh_c;
	logic                stop_ok_c, e_neg_c, bang_neg_c;
	logic [W-2:0]        crm_c;

	always_comb begin
		stop_ok_c = rsq_s2 < {reach_s2, 1'b0};
		e_neg_c   = err_neg_s2 ^ at_stop_s2;
		if (stop_ok_c) begin
			bang_neg_c = err_neg_s2;
		end else begin
			bang_neg_c = (e_neg_c == rate_neg_s2) ? ~e_neg_c : e_neg_c;
		end
		crsh_c = crprod_s2 >> FRACTION_BITS;
		crm_c  = (crsh_c > {{W{1'b0}}, rate_limit_q}) ? rate_limit_q : crsh_c[W-2:0];
	end

	logic [W-2:0]        crm_s3;
	logic                err_neg_s3, bang_neg_s3, bang_s3;
	logic signed [W-1:0] rate_s3;

	// stage 4: rate error
	logic signed [W:0] crm_ext_c, rate_ext_c, rerr_c;

	always_comb begin
		crm_ext_c  = $signed({2'b00, crm_s3});
		rate_ext_c = {rate_s3[W-1], rate_s3};
		rerr_c     = err_neg_s3 ? (-crm_ext_c - rate_ext_c) : (crm_ext_c - rate_ext_c);
	end

	logic signed [W:0]   rerr_s4;
	logic                bang_neg_s4, bang_s4;
	logic signed [W-1:0] rate_s4;

	// stage 5: rate error magnitude
	logic signed [W:0] rerr_inv_c;

	assign rerr_inv_c = -rerr_s4;

	logic [W-1:0]        mrerr_s5;
	logic                rerr_neg_s5, bang_neg_s5, bang_s5;
	logic signed [W-1:0] rate_s5;

	// stage 6: acceleration gain product
	logic [PW-2:0]       amprod_s6;
	logic                rerr_neg_s6, bang_neg_s6, bang_s6;
	logic signed [W-1:0] rate_s6;

	// stage 7: clamp, sign, mode select
	logic [PW-2:0]       amsh_c;
	logic [W-2:0]        am_c;
	logic [W-1:0]        am_w_c, alim_w_c, lin_acc_c, bang_acc_c;

	always_comb begin
		amsh_c     = amprod_s6 >> FRACTION_BITS;
		am_c       = (amsh_c > {{W{1'b0}}, accel_limit_q}) ? accel_limit_q : amsh_c[W-2:0];
		am_w_c     = {1'b0, am_c};
		alim_w_c   = {1'b0, accel_limit_q};
		lin_acc_c  = rerr_neg_s6 ? (~am_w_c + 1'b1) : am_w_c;
		bang_acc_c = bang_neg_s6 ? (~alim_w_c + 1'b1) : alim_w_c;
	end

	logic signed [W-1:0] acc_s7, rate_s7;
	logic                bang_s7;

	always_ff @(posedge clk) begin
		aerr_s1     <= aerr_c;
		arate_s1    <= arate_c;
		err_neg_s1  <= position_error[W-1];
		rate_neg_s1 <= rate[W-1];
		at_stop_s1  <= at_stop_c;
		bang_s1     <= bang_c;
		rate_s1     <= rate;

		rsq_s2      <= arate_s1 * arate_s1;
		reach_s2    <= accel_limit_q * aerr_s1;
		crprod_s2   <= rate_gain_q * aerr_s1;
		err_neg_s2  <= err_neg_s1;
		rate_neg_s2 <= rate_neg_s1;
		at_stop_s2  <= at_stop_s1;
		bang_s2     <= bang_s1;
		rate_s2     <= rate_s1;

		crm_s3      <= crm_c;
		err_neg_s3  <= err_neg_s2;
		bang_neg_s3 <= bang_neg_c;
		bang_s3     <= bang_s2;
		rate_s3     <= rate_s2;

		rerr_s4     <= rerr_c;
		bang_neg_s4 <= bang_neg_s3;
		bang_s4     <= bang_s3;
		rate_s4     <= rate_s3;

		mrerr_s5    <= rerr_s4[W] ? rerr_inv_c[W-1:0] : rerr_s4[W-1:0];
		rerr_neg_s5 <= rerr_s4[W];
		bang_neg_s5 <= bang_neg_s4;
		bang_s5     <= bang_s4;
		rate_s5     <= rate_s4;

		amprod_s6   <= accel_gain_q * mrerr_s5;
		rerr_neg_s6 <= rerr_neg_s5;
		bang_neg_s6 <= bang_neg_s5;
		bang_s6     <= bang_s5;
		rate_s6     <= rate_s5;

		acc_s7      <= bang_s6 ? $signed(bang_acc_c) : $signed(lin_acc_c);
		bang_s7     <= bang_s6;
		rate_s7     <= rate_s6;
	end

	assign done                = valid_s7;
	assign position_derivative = rate_s7;
	assign accel_command       = acc_s7;
	assign bang_mode           = bang_s7;

	// checks
	`BBSAC_ASSERT_IMP(a_latency, clk, arst_n, done, $past(start, LATENCY), "done without a sample taken seven cycles before")
	`BBSAC_ASSERT_IMP(a_rate_pass, clk, arst_n, done, position_derivative == $past(rate, LATENCY), "position derivative does not match the sampled rate")
	`BBSAC_ASSERT_IMP(a_accel_bound, clk, arst_n, done, (accel_command <= $signed({1'b0, accel_limit_q}) && accel_command >= -$signed({1'b0, accel_limit_q})), "acceleration command outside the limit")
	`BBSAC_ASSERT_IMP(a_bang_full, clk, arst_n, done && bang_mode, (accel_command == $signed({1'b0, accel_limit_q}) || accel_command == -$signed({1'b0, accel_limit_q})), "bang-bang word not at full acceleration")

endmodule
